// ----- hdl/cdls_pkg.sv -----
package cdls_pkg;

   localparam int MAX_NEST   = 32;
   localparam int MAX_LINE   = 1024;
   localparam int MAX_PARAMS = 16;

   localparam int DEPTH_W = $clog2(MAX_NEST + 1);
   localparam int POS_W   = $clog2(MAX_LINE + 1);
   localparam int CHAR_W  = 8;
   localparam int PIDX_W  = 4;
   localparam int EPOS_W  = 11;

   // The parameter index saturates at the smaller of MAX_PARAMS-1 and 15.
   localparam logic [PIDX_W-1:0] PARAM_LIMIT =
      PIDX_W'((MAX_PARAMS > 16) ? 15 : (MAX_PARAMS - 1));

   localparam logic [CHAR_W-1:0] CHAR_NUL       = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_QUOTE     = 8'h22;
   localparam logic [CHAR_W-1:0] CHAR_PAREN_O   = 8'h28;
   localparam logic [CHAR_W-1:0] CHAR_PAREN_C   = 8'h29;
   localparam logic [CHAR_W-1:0] CHAR_SQUARE_O  = 8'h5b;
   localparam logic [CHAR_W-1:0] CHAR_SQUARE_C  = 8'h5d;
   localparam logic [CHAR_W-1:0] CHAR_CURLY_O   = 8'h7b;
   localparam logic [CHAR_W-1:0] CHAR_CURLY_C   = 8'h7d;
   localparam logic [CHAR_W-1:0] CHAR_COMMA     = 8'h2c;
   localparam logic [CHAR_W-1:0] CHAR_SEMICOLON = 8'h3b;
   localparam logic [CHAR_W-1:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z   = 8'h5a;
   localparam logic [CHAR_W-1:0] CASE_OFFSET    = 8'h20;

   typedef enum logic [1:0] {
      NEST_NONE   = 2'd0,
      NEST_PAREN  = 2'd1,
      NEST_SQUARE = 2'd2,
      NEST_CURLY  = 2'd3
   } nest_type;

   typedef enum logic [1:0] {
      KIND_ORDINARY  = 2'd0,
      KIND_SEPARATOR = 2'd1,
      KIND_SEGMENT   = 2'd2,
      KIND_LINE_END  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_BRACKETS = 2'd1,
      ERR_QUOTES   = 2'd2
   } error_type;

   typedef struct packed {
      logic     push;
      logic     pop;
      nest_type code;
   } stack_ctl_type;

endpackage

// ----- hdl/cdls_cell.sv -----
module cdls_cell (
   input  logic                   clock,
   input  cdls_pkg::stack_ctl_type ctl,
   input  cdls_pkg::nest_type     from_above,
   input  cdls_pkg::nest_type     from_below,
   output cdls_pkg::nest_type     code
);

   cdls_pkg::nest_type code_ff;
   cdls_pkg::nest_type code_in;

   // On a push every entry moves one place deeper; on a pop one place up.
   always_comb begin
      code_in = code_ff;
      if (ctl.push) begin
         code_in = from_above;
      end else if (ctl.pop) begin
         code_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   assign code = code_ff;

endmodule

// ----- hdl/cdls_stack.sv -----
module cdls_stack (
   input  logic                    clock,
   input  cdls_pkg::stack_ctl_type ctl,
   output cdls_pkg::nest_type      top_code
);

   cdls_pkg::nest_type cell_code [cdls_pkg::MAX_NEST];

   // Cell 0 holds the top of the stack and takes the new code on a push.
   for (genvar i = 0; i < cdls_pkg::MAX_NEST; i++) begin : g_cell
      cdls_pkg::nest_type above;
      cdls_pkg::nest_type below;

      if (i == 0) begin : g_first
         assign above = ctl.code;
      end else begin : g_rest
         assign above = cell_code[i-1];
      end

      if (i == cdls_pkg::MAX_NEST - 1) begin : g_last
         assign below = cdls_pkg::NEST_NONE;
      end else begin : g_inner
         assign below = cell_code[i+1];
      end

      cdls_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .from_above (above),
         .from_below (below),
         .code       (cell_code[i])
      );
   end

   assign top_code = cell_code[0];

endmodule

// ----- hdl/command_line_delimiter_scanner_top.sv -----
// A word accepted by the scanner is held in the result register, which drives the rsp_ ports.
// Throughput: one word per cycle while rsp_stall does not hold the result; each word's whole step,
// including the bracket stack shift through the row of cells, is combinational before the result register.
// The result register frees in the same cycle that its word is taken.
// Reset (synchronous, active high) empties the stack, clears the quote, position,
// parameter and halt state and drops rsp_valid; the stack cells themselves are not cleared.
module command_line_delimiter_scanner_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   output logic [1:0]  rsp_kind,
   output logic [3:0]  rsp_param_index,
   output logic [1:0]  rsp_error,
   output logic [10:0] rsp_error_pos
);

   localparam int DW = cdls_pkg::DEPTH_W;
   localparam int PW = cdls_pkg::POS_W;

   logic [DW-1:0] depth_ff, depth_in;
   logic          quote_ff, quote_in;
   logic [7:0]    prev_ff, prev_in;
   logic [PW-1:0] position_ff, position_in;
   logic [3:0]    pcount_ff, pcount_in;
   logic          halted_ff, halted_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    out_char_ff, out_char_in;
   cdls_pkg::kind_type  kind_ff, kind_in;
   logic [3:0]    pidx_ff, pidx_in;
   cdls_pkg::error_type err_ff, err_in;
   logic [10:0]   epos_ff, epos_in;

   logic                    accept;
   cdls_pkg::stack_ctl_type ctl;
   cdls_pkg::stack_ctl_type step_ctl;
   cdls_pkg::nest_type      top_code;
   cdls_pkg::nest_type      close_code;
   logic [PW-1:0]           epos_full;
   logic                    is_close;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      depth_in    = depth_ff;
      quote_in    = quote_ff;
      pcount_in   = pcount_ff;
      halted_in   = halted_ff;
      out_char_in = req_in_char;
      kind_in     = cdls_pkg::KIND_ORDINARY;
      err_in      = cdls_pkg::ERR_NONE;
      epos_full   = '0;
      step_ctl    = '{push: 1'b0, pop: 1'b0, code: cdls_pkg::NEST_NONE};
      close_code  = cdls_pkg::NEST_NONE;
      is_close    = 1'b0;

      if (halted_ff) begin
         if (req_in_char == cdls_pkg::CHAR_NUL) begin
            kind_in = cdls_pkg::KIND_LINE_END;
         end
      end else if (req_in_char == cdls_pkg::CHAR_NUL) begin
         kind_in = cdls_pkg::KIND_LINE_END;
         if (quote_ff || depth_ff != '0) begin
            err_in    = quote_ff ? cdls_pkg::ERR_QUOTES : cdls_pkg::ERR_BRACKETS;
            epos_full = (position_ff < PW'(cdls_pkg::MAX_LINE)) ? position_ff + 1'b1
                                                                 : PW'(cdls_pkg::MAX_LINE);
         end
      end else if (quote_ff) begin
         if (req_in_char == cdls_pkg::CHAR_QUOTE && prev_ff != cdls_pkg::CHAR_BACKSLASH) begin
            quote_in = 1'b0;
         end
      end else begin
         case (req_in_char)
            cdls_pkg::CHAR_QUOTE:    quote_in = 1'b1;
            cdls_pkg::CHAR_PAREN_O:  step_ctl.code = cdls_pkg::NEST_PAREN;
            cdls_pkg::CHAR_SQUARE_O: step_ctl.code = cdls_pkg::NEST_SQUARE;
            cdls_pkg::CHAR_CURLY_O:  step_ctl.code = cdls_pkg::NEST_CURLY;
            cdls_pkg::CHAR_PAREN_C: begin
               close_code = cdls_pkg::NEST_PAREN;
               is_close   = 1'b1;
            end
            cdls_pkg::CHAR_SQUARE_C: begin
               close_code = cdls_pkg::NEST_SQUARE;
               is_close   = 1'b1;
            end
            cdls_pkg::CHAR_CURLY_C: begin
               close_code = cdls_pkg::NEST_CURLY;
               is_close   = 1'b1;
            end
            cdls_pkg::CHAR_COMMA: begin
               if (depth_ff == '0) begin
                  kind_in = cdls_pkg::KIND_SEPARATOR;
                  if (pcount_ff < cdls_pkg::PARAM_LIMIT) begin
                     pcount_in = pcount_ff + 1'b1;
                  end
               end
            end
            cdls_pkg::CHAR_SEMICOLON: begin
               if (depth_ff == '0) begin
                  kind_in = cdls_pkg::KIND_SEGMENT;
               end
            end
            default: begin
               if (req_in_char inside {[cdls_pkg::CHAR_UPPER_A:cdls_pkg::CHAR_UPPER_Z]}) begin
                  out_char_in = req_in_char + cdls_pkg::CASE_OFFSET;
               end
            end
         endcase

         if (step_ctl.code != cdls_pkg::NEST_NONE) begin
            if (depth_ff == DW'(cdls_pkg::MAX_NEST)) begin
               err_in    = cdls_pkg::ERR_BRACKETS;
               epos_full = position_ff;
               halted_in = 1'b1;
            end else begin
               step_ctl.push = 1'b1;
               depth_in      = depth_ff + 1'b1;
            end
         end

         if (is_close) begin
            if (depth_ff == '0 || top_code != close_code) begin
               err_in    = cdls_pkg::ERR_BRACKETS;
               epos_full = position_ff;
               halted_in = 1'b1;
            end else begin
               step_ctl.pop = 1'b1;
               depth_in     = depth_ff - 1'b1;
            end
         end
      end

      // A separator already counts towards the next parameter.
      pidx_in = pcount_in;
      if (kind_in == cdls_pkg::KIND_SEGMENT) begin
         pcount_in = '0;
      end
      if (halted_ff || req_in_char == cdls_pkg::CHAR_NUL) begin
         pidx_in = pcount_ff;
      end
      epos_in = 11'(epos_full);

      if (req_in_char == cdls_pkg::CHAR_NUL) begin
         depth_in    = '0;
         quote_in    = 1'b0;
         prev_in     = '0;
         position_in = '0;
         pcount_in   = '0;
         halted_in   = 1'b0;
      end else begin
         prev_in     = req_in_char;
         position_in = (position_ff < PW'(cdls_pkg::MAX_LINE)) ? position_ff + 1'b1
                                                                : position_ff;
      end

      rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);
   end

   assign ctl = '{push: step_ctl.push && accept, pop: step_ctl.pop && accept,
                  code: step_ctl.code};

   cdls_stack u_stack (
      .clock    (clock),
      .ctl      (ctl),
      .top_code (top_code)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         quote_ff     <= 1'b0;
         prev_ff      <= '0;
         position_ff  <= '0;
         pcount_ff    <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            depth_ff    <= depth_in;
            quote_ff    <= quote_in;
            prev_ff     <= prev_in;
            position_ff <= position_in;
            pcount_ff   <= pcount_in;
            halted_ff   <= halted_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_char_ff <= out_char_in;
         kind_ff     <= kind_in;
         pidx_ff     <= pidx_in;
         err_ff      <= err_in;
         epos_ff     <= epos_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = out_char_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_param_index = pidx_ff;
   assign rsp_error       = err_ff;
   assign rsp_error_pos   = epos_ff;

   // The stack depth never runs past the number of cells.
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(cdls_pkg::MAX_NEST))
      else $error("stack depth beyond the row of cells");

   // A zero byte returns the line state to its starting point.
   a_line_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_in_char == cdls_pkg::CHAR_NUL) |=>
         (depth_ff == '0 && position_ff == '0 && !halted_ff && !quote_ff))
      else $error("line state not cleared after the line end");

   // An unbalanced quote can only be reported on the line end word.
   a_quote_error_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error == cdls_pkg::ERR_QUOTES) |->
         rsp_kind == cdls_pkg::KIND_LINE_END)
      else $error("quote error away from the line end");

   // A word that raises an error halts the scanner unless it ends the line.
   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      (accept && err_in != cdls_pkg::ERR_NONE && req_in_char != cdls_pkg::CHAR_NUL) |=>
         halted_ff)
      else $error("scanner kept going after an error");

endmodule
